[rtl/utfd_pkg.sv]
// Package: shared types and constants for the UTF-8 byte stream decoder.
package utfd_pkg;

  localparam int ByteW = 8;
  localparam int LeftW = 16;
  localparam int CpW   = 21;
  localparam int LenW  = 3;
  localparam int PendW = 2;
  localparam int InDataW  = 24;
  localparam int OutDataW = 24;

  localparam logic [LenW-1:0] LenOne   = 3'd1;
  localparam logic [LenW-1:0] LenTwo   = 3'd2;
  localparam logic [LenW-1:0] LenThree = 3'd3;
  localparam logic [LenW-1:0] LenFour  = 3'd4;

  typedef struct packed {
    logic [LeftW-1:0] bytes_left;
    logic [ByteW-1:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic            at_end;
    logic [LenW-1:0] byte_count;
    logic [CpW-1:0]  cp_value;
  } result_t;

endpackage

[rtl/utfd_in_reg.sv]
// Input register stage: holds one accepted byte transaction until it is decoded.
module utfd_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  utfd_pkg::in_item_t in_item,
  input  logic               advance,
  output logic               item_valid,
  output utfd_pkg::in_item_t item
);

  logic               valid_r;
  logic               valid_nxt;
  utfd_pkg::in_item_t item_r;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

[rtl/utfd_step.sv]
// Decode step: sequence state registers and per-byte classify / accumulate logic.
module utfd_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  utfd_pkg::in_item_t  item,
  output logic                emit,
  output utfd_pkg::result_t   res
);

  logic [utfd_pkg::PendW-1:0] pend_r, pend_nxt;
  logic [utfd_pkg::CpW-1:0]   acc_r, acc_nxt;
  logic [utfd_pkg::LenW-1:0]  seq_r, seq_nxt;

  logic [utfd_pkg::LenW-1:0]  lead_len;
  logic [utfd_pkg::CpW-1:0]   lead_payload;
  logic                       lead_ok;
  logic [utfd_pkg::CpW-1:0]   shifted;
  logic [utfd_pkg::PendW-1:0] pend_dec;
  logic                       fits;
  logic                       last_byte;

  assign last_byte = (item.bytes_left == utfd_pkg::LeftW'(1));
  assign shifted   = {acc_r[utfd_pkg::CpW-7:0], item.byte_in[5:0]};
  assign pend_dec  = pend_r - utfd_pkg::PendW'(1);
  assign fits      = (item.bytes_left >= utfd_pkg::LeftW'(lead_len));

  always_comb begin
    lead_ok      = 1'b1;
    lead_len     = utfd_pkg::LenOne;
    lead_payload = '0;
    case (item.byte_in) inside
      8'b0???????: begin
        lead_len     = utfd_pkg::LenOne;
        lead_payload = utfd_pkg::CpW'(item.byte_in[6:0]);
      end
      8'b110?????: begin
        lead_len     = utfd_pkg::LenTwo;
        lead_payload = utfd_pkg::CpW'(item.byte_in[4:0]);
      end
      8'b1110????: begin
        lead_len     = utfd_pkg::LenThree;
        lead_payload = utfd_pkg::CpW'(item.byte_in[3:0]);
      end
      8'b11110???: begin
        lead_len     = utfd_pkg::LenFour;
        lead_payload = utfd_pkg::CpW'(item.byte_in[2:0]);
      end
      default: begin
        lead_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    pend_nxt       = pend_r;
    acc_nxt        = acc_r;
    seq_nxt        = seq_r;
    emit           = 1'b0;
    res.cp_value   = shifted;
    res.byte_count = seq_r;
    res.at_end     = last_byte;
    if (fire) begin
      if (pend_r != '0) begin
        if (pend_dec == '0) begin
          emit     = 1'b1;
          pend_nxt = '0;
          acc_nxt  = '0;
          seq_nxt  = '0;
        end else begin
          pend_nxt = pend_dec;
          acc_nxt  = shifted;
        end
      end else if (lead_ok && fits) begin
        if (lead_len == utfd_pkg::LenOne) begin
          emit           = 1'b1;
          res.cp_value   = lead_payload;
          res.byte_count = utfd_pkg::LenOne;
        end else begin
          acc_nxt  = lead_payload;
          seq_nxt  = lead_len;
          pend_nxt = utfd_pkg::PendW'(lead_len - utfd_pkg::LenOne);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      acc_r  <= '0;
      seq_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
      seq_r  <= seq_nxt;
    end
  end

  a_pend_len: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0) |-> (seq_r >= utfd_pkg::LenTwo && seq_r <= utfd_pkg::LenFour &&
                        utfd_pkg::LenW'(pend_r) < seq_r))
    else $error("pending count inconsistent with sequence length");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == '0) |-> (acc_r == '0 && seq_r == '0))
    else $error("accumulator not cleared between sequences");

  a_ascii_range: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && res.byte_count == utfd_pkg::LenOne) |-> (res.cp_value[utfd_pkg::CpW-1:7] == '0))
    else $error("single-byte code point out of range");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && res.byte_count != utfd_pkg::LenOne) |=> (pend_r == '0))
    else $error("sequence still pending after completion");

endmodule

[rtl/utf8_byte_stream_decoder_core.sv]
// Top level: UTF-8 byte stream decoder with input register and result register.
//
// Usage:
//   in_*  : one byte per transaction with the count of bytes left in the
//           string (this byte included). Leading bytes are classified and
//           continuation bytes are shifted into the partial code point.
//   out_* : one transaction per completed code point: 21-bit value and its
//           byte length in tdata, tlast set when the completing byte had
//           bytes_left equal to one. Skipped bytes produce no transaction.
//   A taken byte is held in the input register; when the output is not
//   stalled, the decode step writes its result into the result register,
//   from where it is offered until the receiver takes it.
//   Throughput: one byte per cycle unless the receiver stalls, set by the
//   single decode step between the input register and the result register.
//   Reset (rst_n low, synchronous) empties both registers and clears the
//   sequence state. When the receiver stalls, the result register holds;
//   at most one more byte is taken into the input register, then in_tready
//   stays low until the result is taken.
module utf8_byte_stream_decoder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [utfd_pkg::InDataW-1:0]  in_tdata,   // byte_in[7:0], bytes_left[23:8]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [utfd_pkg::OutDataW-1:0] out_tdata,  // cp_value[20:0], byte_count[23:21]
  output logic                          out_tlast   // at_end
);

  utfd_pkg::in_item_t in_item;
  utfd_pkg::in_item_t item;
  utfd_pkg::result_t  res;
  utfd_pkg::result_t  res_r;
  logic               item_valid;
  logic               advance;
  logic               emit;
  logic               out_valid_r, out_valid_nxt;

  assign in_item = utfd_pkg::in_item_t'(in_tdata);
  assign advance = !out_valid_r || out_tready;

  utfd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  utfd_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (item_valid && advance),
    .item  (item),
    .emit  (emit),
    .res   (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = item_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid && emit) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.byte_count, res_r.cp_value};
  assign out_tlast  = res_r.at_end;

endmodule
